FILE: design/bmdr_pkg.sv
// ----------------------------------------------------------------------------
// bmdr_pkg
// Shared types, field widths and constants of the bicycle-model odometry core.
// ----------------------------------------------------------------------------
`default_nettype none

package bmdr_pkg;

   localparam int SPEED_W   = 16;
   localparam int STEER_W   = 15;
   localparam int TIME_W    = 20;
   localparam int POS_OUT_W = 40;
   localparam int HEAD_W    = 16;
   localparam int WB_W      = 13;

   localparam int MUL_A_W   = 48;
   localparam int MUL_B_W   = 32;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W   = 64;
   localparam int DIV_D_W   = 44;
   localparam int COR_W     = 34;
   localparam int DIFF_W    = COR_W + 1;
   localparam int DELTA_W   = 50;
   localparam int S_MAG_W   = 27;
   localparam int FRAC_W    = 20;

   localparam logic [WB_W-1:0]          WB_RESET    = 13'd1200;
   localparam logic [FRAC_W-1:0]        TURN_SCALE  = 20'd683565;
   localparam logic signed [COR_W-1:0]  CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [COR_W-1:0]  MIN_SIN     = 34'sd128;
   localparam logic [DIV_D_W-1:0]       UM_PER_MM   = 44'd1000;
   localparam logic [DIV_N_W-1:0]       HALF_MM     = 64'd500;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PMUL,
      S_SDIV,
      S_SCOR,
      S_DEN,
      S_NUM,
      S_QDIV,
      S_RTS,
      S_FDIV,
      S_QTS,
      S_C0,
      S_C1,
      S_LK,
      S_LKC,
      S_RDIV,
      S_DX,
      S_DY,
      S_UPD
   } state_type;

   typedef enum logic [1:0] {
      UNIT_NONE,
      UNIT_MUL,
      UNIT_DIV,
      UNIT_COR
   } unit_type;

   // arctangent of 2^-k as a 32-bit binary angle
   function automatic logic [31:0] atan_entry(input logic [4:0] k);
      logic [31:0] a;
      unique case (k)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000029;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000003;
         5'd29: a = 32'h00000001;
         5'd30: a = 32'h00000001;
         5'd31: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

FILE: design/bmdr_if.sv
// ----------------------------------------------------------------------------
// bmdr channel interfaces
// Valid/ready channels for drive commands and pose results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmdr_req_if import bmdr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] speed_mm_s;
   logic signed [STEER_W-1:0] steer_angle;
   logic [TIME_W-1:0]         elapsed_us;

   modport source (output valid, output speed_mm_s, output steer_angle,
                   output elapsed_us, input ready);
   modport sink   (input valid, input speed_mm_s, input steer_angle,
                   input elapsed_us, output ready);
endinterface

interface bmdr_rsp_if import bmdr_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [POS_OUT_W-1:0] pos_x_um;
   logic signed [POS_OUT_W-1:0] pos_y_um;
   logic [HEAD_W-1:0]           heading_angle;
   logic                        saturated;

   modport source (output valid, output pos_x_um, output pos_y_um,
                   output heading_angle, output saturated, input ready);
   modport sink   (input valid, input pos_x_um, input pos_y_um,
                   input heading_angle, input saturated, output ready);
endinterface

`default_nettype wire

FILE: design/bicycle_model_dead_reckoning_core.sv
// ----------------------------------------------------------------------------
// bicycle_model_dead_reckoning_core
// Fixed-point bicycle-model pose integrator with serial arithmetic units.
// ----------------------------------------------------------------------------
// Each drive command (speed, steering, elapsed time) advances the stored pose
// along a straight line or an exact arc and returns the new pose. One command
// is worked at a time by a sequencer over three shared serial units: a
// shift-add multiplier (one multiplier bit per cycle), a restoring divider
// (one quotient bit per cycle) and a CORDIC rotator (CORDIC_STEPS iterations).
// A straight move takes 3 multiplies, 1 divide and 1 rotation; an arc takes
// 9 multiplies, 4 divides and 3 rotations. The next command is taken while
// the previous pose still waits on the result channel. The wheelbase register
// is written through csr_wr_en/csr_wr_data; the user must write it only while
// no command is open, as the block itself does not enforce this.
`default_nettype none

module bicycle_model_dead_reckoning_core import bmdr_pkg::*; #(
   parameter int POSITION_BITS = 40,
   parameter int CORDIC_STEPS  = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_wr_en,
   input  wire logic [WB_W-1:0] csr_wr_data,
   bmdr_req_if.sink             req_chan,
   bmdr_rsp_if.source           rsp_chan
);

   localparam int SUM_W = ((POSITION_BITS > DELTA_W) ? POSITION_BITS : DELTA_W) + 1;
   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MUL_B_W);
   localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIV_N_W);
   localparam logic [CNT_W-1:0] COR_STEPS = CNT_W'(CORDIC_STEPS);
   localparam logic signed [SUM_W-1:0] POS_HI =
      {{(SUM_W-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] POS_LO = ~POS_HI;

   // sequencer and command state
   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [WB_W-1:0]             wb_ff, wb_in;
   logic                        v_neg_ff, v_neg_in;
   logic                        st_neg_ff, st_neg_in;
   logic [13:0]                 st_mag_ff, st_mag_in;
   logic [S_MAG_W-1:0]          s_mag_ff, s_mag_in;
   logic [30:0]                 cs_ff, cs_in;
   logic [30:0]                 ss_ff, ss_in;
   logic [DIV_D_W-1:0]          den_ff, den_in;
   logic [DIV_N_W-1:0]          q_ff, q_in;
   logic [FRAC_W-1:0]           frac_ff, frac_in;
   logic                        turn_ff, turn_in;
   logic [31:0]                 end_ff, end_in;
   logic signed [COR_W-1:0]     c0_ff, c0_in, s0_ff, s0_in;
   logic signed [DIFF_W-1:0]    ds_ff, ds_in, dc_ff, dc_in;
   logic [MUL_A_W-1:0]          r_mag_ff, r_mag_in;
   logic signed [DELTA_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;

   // pose and result
   logic signed [POSITION_BITS-1:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic [HEAD_W-1:0]           heading_ff, heading_in;
   logic                        clip_ff, clip_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // serial units
   logic [MUL_A_W-1:0]          mul_a_ff, mul_a_in;
   logic [MUL_B_W-1:0]          mul_b_ff, mul_b_in;
   logic [MUL_P_W-1:0]          mul_acc_ff, mul_acc_in;
   logic                        mul_neg_ff, mul_neg_in;
   logic [DIV_N_W-1:0]          div_quo_ff, div_quo_in;
   logic [DIV_D_W-1:0]          div_rem_ff, div_rem_in;
   logic [DIV_D_W-1:0]          div_den_ff, div_den_in;
   logic signed [COR_W-1:0]     cor_x_ff, cor_x_in, cor_y_ff, cor_y_in;
   logic signed [COR_W-1:0]     cor_z_ff, cor_z_in;
   logic                        cor_flip_ff, cor_flip_in;

   unit_type                    unit_sel;
   logic                        cnt_zero, out_free, pre_turn, sin_ok, turn_ok;
   logic [WB_W-1:0]             wb_eff;
   logic [SPEED_W-1:0]          v_abs;
   logic [STEER_W-1:0]          st_abs;
   logic [31:0]                 th_q;

   // unit step logic
   logic [MUL_A_W:0]            mul_sum;
   logic [MUL_P_W-1:0]          mul_step_acc, mul_rnd;
   logic [DELTA_W-2:0]          mul_mag;
   logic signed [DELTA_W-1:0]   mul_delta;
   logic [DIV_D_W:0]            div_trial, div_diff;
   logic                        div_fit;
   logic [CNT_W-1:0]            cor_idx;
   logic [4:0]                  cor_k;
   logic signed [COR_W-1:0]     cor_xs, cor_ys, cor_atan, cor_c, cor_s, cor_c_abs;
   logic signed [COR_W-1:0]     s0_abs, cor_z0;
   logic [30:0]                 cs_clamp;
   logic [31:0]                 cor_ang, cor_ang2;
   logic                        cor_flip0;
   logic signed [DIFF_W-1:0]    ds_abs, dc_abs;
   logic [31:0]                 dq_mag, dq_signed, head_sum;
   logic signed [SUM_W-1:0]     sum_x, sum_y;
   logic signed [POSITION_BITS-1:0] sat_x, sat_y;
   logic                        clip_x, clip_y;
   logic signed [63:0]          pose_x64, pose_y64;

   assign cnt_zero = (cnt_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign wb_eff   = (wb_ff == '0) ? WB_W'(1) : wb_ff;
   assign th_q     = {heading_ff, 16'b0};
   assign v_abs    = req_chan.speed_mm_s[SPEED_W-1] ? SPEED_W'(-req_chan.speed_mm_s)
                                                    : SPEED_W'(req_chan.speed_mm_s);
   assign st_abs   = req_chan.steer_angle[STEER_W-1] ? STEER_W'(-req_chan.steer_angle)
                                                     : STEER_W'(req_chan.steer_angle);

   // multiplier: right-shifting accumulator, one bit of b per cycle
   assign mul_sum      = {1'b0, mul_acc_ff[MUL_P_W-1:MUL_B_W]}
                       + (mul_b_ff[0] ? {1'b0, mul_a_ff} : '0);
   assign mul_step_acc = {mul_sum, mul_acc_ff[MUL_B_W-1:1]};
   assign mul_rnd      = mul_acc_ff + (MUL_P_W'(1) << 29);
   assign mul_mag      = mul_rnd[30 +: DELTA_W-1];
   assign mul_delta    = mul_neg_ff ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});

   // restoring divider
   assign div_trial = {div_rem_ff, div_quo_ff[DIV_N_W-1]};
   assign div_fit   = (div_trial >= {1'b0, div_den_ff});
   assign div_diff  = div_trial - {1'b0, div_den_ff};

   // cordic rotator
   assign cor_idx   = COR_STEPS - cnt_ff;
   assign cor_k     = cor_idx[4:0];
   assign cor_xs    = cor_x_ff >>> cor_k;
   assign cor_ys    = cor_y_ff >>> cor_k;
   assign cor_atan  = $signed({2'b00, atan_entry(cor_k)});
   assign cor_c     = cor_flip_ff ? -cor_x_ff : cor_x_ff;
   assign cor_s     = cor_flip_ff ? -cor_y_ff : cor_y_ff;
   assign cor_c_abs = cor_c[COR_W-1] ? -cor_c : cor_c;
   assign s0_abs    = s0_ff[COR_W-1] ? -s0_ff : s0_ff;
   assign cs_clamp  = (cor_c < 34'sd1) ? 31'd1 : cor_c[30:0];
   assign ds_abs    = ds_ff[DIFF_W-1] ? -ds_ff : ds_ff;
   assign dc_abs    = dc_ff[DIFF_W-1] ? -dc_ff : dc_ff;

   // rotation start angle, folded into the right half plane
   always_comb begin
      unique case (state_ff)
         S_SDIV:  cor_ang = pre_turn ? {2'b00, st_mag_ff, 16'b0} : th_q;
         S_C0:    cor_ang = end_ff;
         default: cor_ang = th_q;
      endcase
   end
   assign cor_flip0 = cor_ang[31] ^ cor_ang[30];
   assign cor_ang2  = cor_flip0 ? {~cor_ang[31], cor_ang[30:0]} : cor_ang;
   assign cor_z0    = COR_W'($signed(cor_ang2));

   assign pre_turn  = (st_mag_ff != '0) && (div_quo_ff != '0);
   assign sin_ok    = (cor_s >= MIN_SIN);
   assign turn_ok   = (q_ff != '0) || (frac_ff != '0);
   assign dq_mag    = mul_acc_ff[31:0] + 32'(frac_ff);
   assign dq_signed = (v_neg_ff != st_neg_ff) ? (32'd0 - dq_mag) : dq_mag;
   assign head_sum  = end_ff + 32'h0000_8000;

   // saturating position update
   assign sum_x  = SUM_W'(pose_x_ff) + SUM_W'(dx_ff);
   assign sum_y  = SUM_W'(pose_y_ff) + SUM_W'(dy_ff);
   assign clip_x = (sum_x > POS_HI) || (sum_x < POS_LO);
   assign clip_y = (sum_y > POS_HI) || (sum_y < POS_LO);
   assign sat_x  = (sum_x > POS_HI) ? POS_HI[POSITION_BITS-1:0] :
                   (sum_x < POS_LO) ? POS_LO[POSITION_BITS-1:0] : sum_x[POSITION_BITS-1:0];
   assign sat_y  = (sum_y > POS_HI) ? POS_HI[POSITION_BITS-1:0] :
                   (sum_y < POS_LO) ? POS_LO[POSITION_BITS-1:0] : sum_y[POSITION_BITS-1:0];

   always_comb begin
      unique case (state_ff)
         S_PMUL, S_DEN, S_NUM, S_RTS, S_QTS, S_LK, S_LKC, S_DX, S_DY: unit_sel = UNIT_MUL;
         S_SDIV, S_QDIV, S_FDIV, S_RDIV:                              unit_sel = UNIT_DIV;
         S_SCOR, S_C0, S_C1:                                          unit_sel = UNIT_COR;
         default:                                                     unit_sel = UNIT_NONE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_chan.valid) state_in = S_PMUL;
         S_PMUL: if (cnt_zero) state_in = S_SDIV;
         S_SDIV: if (cnt_zero) state_in = pre_turn ? S_SCOR : S_C0;
         S_SCOR: if (cnt_zero) state_in = sin_ok ? S_DEN : S_C0;
         S_DEN:  if (cnt_zero) state_in = S_NUM;
         S_NUM:  if (cnt_zero) state_in = S_QDIV;
         S_QDIV: if (cnt_zero) state_in = S_RTS;
         S_RTS:  if (cnt_zero) state_in = S_FDIV;
         S_FDIV: if (cnt_zero) state_in = S_QTS;
         S_QTS:  if (cnt_zero) state_in = S_C0;
         S_C0:   if (cnt_zero) state_in = turn_ff ? S_C1 : S_DX;
         S_C1:   if (cnt_zero) state_in = S_LK;
         S_LK:   if (cnt_zero) state_in = S_LKC;
         S_LKC:  if (cnt_zero) state_in = S_RDIV;
         S_RDIV: if (cnt_zero) state_in = S_DX;
         S_DX:   if (cnt_zero) state_in = S_DY;
         S_DY:   if (cnt_zero) state_in = S_UPD;
         S_UPD:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign req_chan.ready = (state_ff == S_IDLE);

   // datapath
   always_comb begin
      cnt_in      = cnt_ff;
      wb_in       = csr_wr_en ? csr_wr_data : wb_ff;
      v_neg_in    = v_neg_ff;
      st_neg_in   = st_neg_ff;
      st_mag_in   = st_mag_ff;
      s_mag_in    = s_mag_ff;
      cs_in       = cs_ff;
      ss_in       = ss_ff;
      den_in      = den_ff;
      q_in        = q_ff;
      frac_in     = frac_ff;
      turn_in     = turn_ff;
      end_in      = end_ff;
      c0_in       = c0_ff;
      s0_in       = s0_ff;
      ds_in       = ds_ff;
      dc_in       = dc_ff;
      r_mag_in    = r_mag_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      pose_x_in   = pose_x_ff;
      pose_y_in   = pose_y_ff;
      heading_in  = heading_ff;
      clip_in     = clip_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_chan.ready) ? 1'b0 : rsp_valid_ff;
      mul_a_in    = mul_a_ff;
      mul_b_in    = mul_b_ff;
      mul_acc_in  = mul_acc_ff;
      mul_neg_in  = mul_neg_ff;
      div_quo_in  = div_quo_ff;
      div_rem_in  = div_rem_ff;
      div_den_in  = div_den_ff;
      cor_x_in    = cor_x_ff;
      cor_y_in    = cor_y_ff;
      cor_z_in    = cor_z_ff;
      cor_flip_in = cor_flip_ff;

      if (!cnt_zero) begin
         cnt_in = cnt_ff - CNT_W'(1);
         unique case (unit_sel)
            UNIT_MUL: begin
               mul_acc_in = mul_step_acc;
               mul_b_in   = mul_b_ff >> 1;
            end
            UNIT_DIV: begin
               div_rem_in = div_fit ? div_diff[DIV_D_W-1:0] : div_trial[DIV_D_W-1:0];
               div_quo_in = {div_quo_ff[DIV_N_W-2:0], div_fit};
            end
            UNIT_COR: begin
               if (!cor_z_ff[COR_W-1]) begin
                  cor_x_in = cor_x_ff - cor_ys;
                  cor_y_in = cor_y_ff + cor_xs;
                  cor_z_in = cor_z_ff - cor_atan;
               end else begin
                  cor_x_in = cor_x_ff + cor_ys;
                  cor_y_in = cor_y_ff - cor_xs;
                  cor_z_in = cor_z_ff + cor_atan;
               end
            end
            default: begin
            end
         endcase
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  v_neg_in   = req_chan.speed_mm_s[SPEED_W-1];
                  st_neg_in  = req_chan.steer_angle[STEER_W-1];
                  // a full right-angle lock is clamped one step short
                  st_mag_in  = st_abs[STEER_W-1] ? 14'h3FFF : st_abs[13:0];
                  turn_in    = 1'b0;
                  mul_a_in   = MUL_A_W'(v_abs);
                  mul_b_in   = MUL_B_W'(req_chan.elapsed_us);
                  mul_neg_in = 1'b0;
                  mul_acc_in = '0;
                  cnt_in     = MUL_STEPS;
               end
            end
            S_PMUL: begin
               div_quo_in = mul_acc_ff[DIV_N_W-1:0] + HALF_MM;
               div_rem_in = '0;
               div_den_in = UM_PER_MM;
               cnt_in     = DIV_STEPS;
            end
            S_SDIV: begin
               s_mag_in    = div_quo_ff[S_MAG_W-1:0];
               cor_x_in    = CORDIC_GAIN;
               cor_y_in    = '0;
               cor_z_in    = cor_z0;
               cor_flip_in = cor_flip0;
               cnt_in      = COR_STEPS;
            end
            S_SCOR: begin
               cs_in = cs_clamp;
               ss_in = cor_s[30:0];
               if (sin_ok) begin
                  mul_a_in   = MUL_A_W'(cs_clamp);
                  mul_b_in   = MUL_B_W'(wb_eff);
                  mul_neg_in = 1'b0;
                  mul_acc_in = '0;
                  cnt_in     = MUL_STEPS;
               end else begin
                  // radius beyond range: go straight
                  cor_x_in    = CORDIC_GAIN;
                  cor_y_in    = '0;
                  cor_z_in    = cor_z0;
                  cor_flip_in = cor_flip0;
                  cnt_in      = COR_STEPS;
               end
            end
            S_DEN: begin
               den_in     = mul_acc_ff[DIV_D_W-1:0];
               mul_a_in   = MUL_A_W'(s_mag_ff);
               mul_b_in   = MUL_B_W'(ss_ff);
               mul_acc_in = '0;
               cnt_in     = MUL_STEPS;
            end
            S_NUM: begin
               div_quo_in = mul_acc_ff[DIV_N_W-1:0];
               div_rem_in = '0;
               div_den_in = den_ff;
               cnt_in     = DIV_STEPS;
            end
            S_QDIV: begin
               q_in       = div_quo_ff;
               mul_a_in   = MUL_A_W'(div_rem_ff);
               mul_b_in   = MUL_B_W'(TURN_SCALE);
               mul_acc_in = '0;
               cnt_in     = MUL_STEPS;
            end
            S_RTS: begin
               div_quo_in = mul_acc_ff[DIV_N_W-1:0];
               div_rem_in = '0;
               div_den_in = den_ff;
               cnt_in     = DIV_STEPS;
            end
            S_FDIV: begin
               frac_in    = div_quo_ff[FRAC_W-1:0];
               // only the low word of q times the scale survives the wrap
               mul_a_in   = q_ff[MUL_A_W-1:0];
               mul_b_in   = MUL_B_W'(TURN_SCALE);
               mul_acc_in = '0;
               cnt_in     = MUL_STEPS;
            end
            S_QTS: begin
               turn_in     = turn_ok;
               end_in      = th_q + dq_signed;
               cor_x_in    = CORDIC_GAIN;
               cor_y_in    = '0;
               cor_z_in    = cor_z0;
               cor_flip_in = cor_flip0;
               cnt_in      = COR_STEPS;
            end
            S_C0: begin
               c0_in = cor_c;
               s0_in = cor_s;
               if (turn_ff) begin
                  cor_x_in    = CORDIC_GAIN;
                  cor_y_in    = '0;
                  cor_z_in    = cor_z0;
                  cor_flip_in = cor_flip0;
                  cnt_in      = COR_STEPS;
               end else begin
                  mul_a_in   = MUL_A_W'(s_mag_ff);
                  mul_b_in   = cor_c_abs[MUL_B_W-1:0];
                  mul_neg_in = v_neg_ff ^ cor_c[COR_W-1];
                  mul_acc_in = '0;
                  cnt_in     = MUL_STEPS;
               end
            end
            S_C1: begin
               ds_in      = DIFF_W'(cor_s) - DIFF_W'(s0_ff);
               dc_in      = DIFF_W'(c0_ff) - DIFF_W'(cor_c);
               mul_a_in   = MUL_A_W'(wb_eff);
               mul_b_in   = MUL_B_W'(UM_PER_MM);
               mul_neg_in = 1'b0;
               mul_acc_in = '0;
               cnt_in     = MUL_STEPS;
            end
            S_LK: begin
               mul_a_in   = mul_acc_ff[MUL_A_W-1:0];
               mul_b_in   = MUL_B_W'(cs_ff);
               mul_acc_in = '0;
               cnt_in     = MUL_STEPS;
            end
            S_LKC: begin
               div_quo_in = mul_acc_ff[DIV_N_W-1:0];
               div_rem_in = '0;
               div_den_in = DIV_D_W'(ss_ff);
               cnt_in     = DIV_STEPS;
            end
            S_RDIV: begin
               r_mag_in   = div_quo_ff[MUL_A_W-1:0];
               mul_a_in   = div_quo_ff[MUL_A_W-1:0];
               mul_b_in   = ds_abs[MUL_B_W-1:0];
               mul_neg_in = st_neg_ff ^ ds_ff[DIFF_W-1];
               mul_acc_in = '0;
               cnt_in     = MUL_STEPS;
            end
            S_DX: begin
               dx_in      = mul_delta;
               mul_acc_in = '0;
               cnt_in     = MUL_STEPS;
               if (turn_ff) begin
                  mul_a_in   = r_mag_ff;
                  mul_b_in   = dc_abs[MUL_B_W-1:0];
                  mul_neg_in = st_neg_ff ^ dc_ff[DIFF_W-1];
               end else begin
                  mul_a_in   = MUL_A_W'(s_mag_ff);
                  mul_b_in   = s0_abs[MUL_B_W-1:0];
                  mul_neg_in = v_neg_ff ^ s0_ff[COR_W-1];
               end
            end
            S_DY: begin
               dy_in = mul_delta;
            end
            S_UPD: begin
               if (out_free) begin
                  pose_x_in    = sat_x;
                  pose_y_in    = sat_y;
                  clip_in      = clip_x || clip_y;
                  rsp_valid_in = 1'b1;
                  if (turn_ff) begin
                     heading_in = head_sum[31:16];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         wb_ff        <= WB_RESET;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         heading_ff   <= '0;
         clip_ff      <= 1'b0;
         turn_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wb_ff        <= wb_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         heading_ff   <= heading_in;
         clip_ff      <= clip_in;
         turn_ff      <= turn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_neg_ff    <= v_neg_in;
      st_neg_ff   <= st_neg_in;
      st_mag_ff   <= st_mag_in;
      s_mag_ff    <= s_mag_in;
      cs_ff       <= cs_in;
      ss_ff       <= ss_in;
      den_ff      <= den_in;
      q_ff        <= q_in;
      frac_ff     <= frac_in;
      end_ff      <= end_in;
      c0_ff       <= c0_in;
      s0_ff       <= s0_in;
      ds_ff       <= ds_in;
      dc_ff       <= dc_in;
      r_mag_ff    <= r_mag_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_acc_ff  <= mul_acc_in;
      mul_neg_ff  <= mul_neg_in;
      div_quo_ff  <= div_quo_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      cor_x_ff    <= cor_x_in;
      cor_y_ff    <= cor_y_in;
      cor_z_ff    <= cor_z_in;
      cor_flip_ff <= cor_flip_in;
   end

   assign pose_x64               = 64'(pose_x_ff);
   assign pose_y64               = 64'(pose_y_ff);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pos_x_um      = pose_x64[POS_OUT_W-1:0];
   assign rsp_chan.pos_y_um      = pose_y64[POS_OUT_W-1:0];
   assign rsp_chan.heading_angle = heading_ff;
   assign rsp_chan.saturated     = clip_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == S_PMUL))
      else $error("accepted transaction did not start the sequencer");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (unit_sel == UNIT_DIV) |-> (div_den_ff != '0))
      else $error("divider running with a zero divisor");

   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("pose update did not post a result");

   a_straight_heading: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && out_free && !turn_ff) |=> $stable(heading_ff))
      else $error("heading changed on a straight move");

endmodule

`default_nettype wire
